@@ src/granule_posting_decoder_unit_macros.svh @@
// assertion macros for the granule posting decoder rtl
`ifndef GRANULE_POSTING_DECODER_UNIT_MACROS_SVH
`define GRANULE_POSTING_DECODER_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define GPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define GPD_ASSERT_IMP(lbl, ante, cons, msg) \
  `GPD_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ src/gpd_pkg.sv @@
// shared types and constants of the granule posting decoder
package gpd_pkg;

  localparam int unsigned ROW_BITS     = 40;
  localparam int unsigned GRANULE_BITS = 32;
  localparam int unsigned CFG_BITS     = 40;

  typedef enum logic [1:0] {
    CFG_MODE          = 2'd0,
    CFG_GRANULE_ROWS  = 2'd1,
    CFG_TOTAL_ROWS    = 2'd2,
    CFG_GRANULE_COUNT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_BEYOND   = 2'd2,
    ST_TRAILING = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_OFFER = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_DROP  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    logic                     mode;
    logic [GRANULE_BITS-1:0]  granule_rows;
    logic [ROW_BITS-1:0]      total_rows;
    logic [GRANULE_BITS-1:0]  granule_count;
  } gpd_cfg_t;

  // command in granule units, from the decoder
  typedef struct packed {
    cmd_kind_e                kind;
    logic                     eob;
    logic                     fin;
    status_e                  status;
    logic [GRANULE_BITS-1:0]  glo;
    logic [GRANULE_BITS-1:0]  ghi;
  } gpd_cmd_t;

  // command in row units, queued for the back end
  typedef struct packed {
    cmd_kind_e                kind;
    logic                     eob;
    logic                     fin;
    status_e                  status;
    logic                     keep;
    logic [ROW_BITS-1:0]      first_row;
    logic [ROW_BITS-1:0]      end_row;
  } gpd_ent_t;

  typedef struct packed {
    logic                     range_valid;
    logic [ROW_BITS-1:0]      first_row;
    logic [ROW_BITS-1:0]      end_row;
    logic                     posting_done;
    status_e                  status;
    logic                     last;
  } gpd_res_t;

endpackage

@@ src/gpd_front.sv @@
// posting byte decoder and granule run scanner
module gpd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gpd_pkg::gpd_cfg_t cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        posting_byte_i,
  input  logic              final_byte_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output gpd_pkg::gpd_cmd_t cmd_o
);
  import gpd_pkg::*;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_GAP   = 3'd1,
    PH_LEN   = 3'd2,
    PH_DONE  = 3'd3,
    PH_DRAIN = 3'd4
  } phase_e;

  phase_e                  ph_q, ph_d;
  logic [63:0]             acc_q, acc_d;
  logic [6:0]              shift_q, shift_d;
  logic [63:0]             runs_q, runs_d;
  logic [GRANULE_BITS-1:0] gpos_q, gpos_d;
  logic [GRANULE_BITS-1:0] held_q, held_d;
  logic [29:0]             bidx_q, bidx_d;
  status_e                 err_q, err_d;

  // scanner holding register
  logic                    b_valid_q;
  logic [7:0]              b_mask_q;
  logic [GRANULE_BITS-1:0] b_base_q;
  logic                    b_run_q;
  logic [GRANULE_BITS-1:0] b_lo_q, b_hi_q;
  cmd_kind_e               b_tail_q;
  logic                    b_fin_q;
  status_e                 b_status_q;

  logic [7:0]              ld_mask;
  logic                    ld_run;
  logic [GRANULE_BITS-1:0] ld_lo, ld_hi;
  cmd_kind_e               ld_tail;
  status_e                 ld_status;
  logic                    ld_any;

  logic [29:0]             width;
  logic [6:0]              payload;
  logic [63:0]             val;
  logic [32:0]             sum33;
  logic                    in_acc;

  logic [7:0]              lowbit, runbits, mask_nx;
  logic [8:0]              sum9;
  logic [2:0]              lpos;
  logic [3:0]              klen;
  logic [GRANULE_BITS-1:0] glo;
  logic                    rem, issue, last_issue;

  // byte decode
  always_comb begin
    ph_d      = ph_q;
    acc_d     = acc_q;
    shift_d   = shift_q;
    runs_d    = runs_q;
    gpos_d    = gpos_q;
    held_d    = held_q;
    bidx_d    = bidx_q;
    err_d     = err_q;
    ld_mask   = '0;
    ld_run    = 1'b0;
    ld_lo     = '0;
    ld_hi     = '0;
    ld_tail   = CMD_NOP;
    ld_status = ST_OK;
    width     = 30'(({1'b0, cfg_i.granule_count} + 33'd7) >> 3);
    payload   = posting_byte_i[6:0];
    val       = acc_q | (64'(payload) << shift_q[5:0]);
    sum33     = '0;
    if (ph_q == PH_START && !cfg_i.mode) begin
      if (bidx_q >= width) begin
        err_d = ST_TRAILING; ph_d = PH_DRAIN; ld_tail = CMD_DROP;
      end else if (bidx_q == width - 30'd1 && cfg_i.granule_count[2:0] != 3'd0 &&
                   8'(posting_byte_i >> cfg_i.granule_count[2:0]) != 8'd0) begin
        err_d = ST_BEYOND; ph_d = PH_DRAIN; ld_tail = CMD_DROP;
      end else begin
        ld_mask = posting_byte_i;
        bidx_d  = bidx_q + 30'd1;
        if (bidx_q + 30'd1 == width) begin
          ld_tail = CMD_FLUSH; ph_d = PH_DONE;
        end
      end
    end else if (ph_q == PH_START || ph_q == PH_GAP || ph_q == PH_LEN) begin
      if (shift_q >= 7'd63 && (payload > 7'd1 || posting_byte_i[7])) begin
        err_d = ST_TRUNC; ph_d = PH_DRAIN; ld_tail = CMD_DROP;
      end else if (posting_byte_i[7]) begin
        acc_d   = val;
        shift_d = shift_q + 7'd7;
      end else begin
        acc_d   = '0;
        shift_d = '0;
        case (ph_q)
          PH_START: begin
            runs_d = val;
            gpos_d = '0;
            if (val == 64'd0) begin
              ld_tail = CMD_FLUSH; ph_d = PH_DONE;
            end else begin
              ph_d = PH_GAP;
            end
          end
          PH_GAP: begin
            sum33 = {1'b0, gpos_q} + 33'(val[GRANULE_BITS-1:0]);
            if (val > 64'(cfg_i.granule_count) || sum33 > 33'(cfg_i.granule_count)) begin
              err_d = ST_BEYOND; ph_d = PH_DRAIN; ld_tail = CMD_DROP;
            end else begin
              held_d = sum33[GRANULE_BITS-1:0];
              ph_d   = PH_LEN;
            end
          end
          default: begin
            sum33 = {1'b0, held_q} + 33'(val[GRANULE_BITS-1:0]) + 33'd1;
            if (val >= 64'(cfg_i.granule_count) ||
                sum33 > 33'(cfg_i.granule_count)) begin
              err_d = ST_BEYOND; ph_d = PH_DRAIN; ld_tail = CMD_DROP;
            end else begin
              ld_run = 1'b1;
              ld_lo  = held_q;
              ld_hi  = sum33[GRANULE_BITS-1:0];
              gpos_d = sum33[GRANULE_BITS-1:0];
              runs_d = runs_q - 64'd1;
              if (runs_q == 64'd1) begin
                ld_tail = CMD_FLUSH; ph_d = PH_DONE;
              end else begin
                ph_d = PH_GAP;
              end
            end
          end
        endcase
      end
    end else if (ph_q == PH_DONE) begin
      err_d = ST_TRAILING; ph_d = PH_DRAIN; ld_tail = CMD_DROP;
    end
    if (final_byte_i) begin
      if (err_d != ST_OK) ld_status = err_d;
      else if (ph_d == PH_DONE) ld_status = ST_OK;
      else ld_status = ST_TRUNC;
      // posting ends: back to idle decode state
      ph_d    = PH_START;
      acc_d   = '0;
      shift_d = '0;
      runs_d  = '0;
      gpos_d  = '0;
      held_d  = '0;
      bidx_d  = '0;
      err_d   = ST_OK;
    end
    ld_any = (ld_mask != 8'd0) || ld_run || (ld_tail != CMD_NOP) || final_byte_i;
  end

  // scanner: one contiguous run of set granules per cycle while cmd_ready_i is high
  always_comb begin
    lowbit  = b_mask_q & (~b_mask_q + 8'd1);
    sum9    = {1'b0, b_mask_q} + {1'b0, lowbit};
    runbits = b_mask_q & ~sum9[7:0];
    mask_nx = b_mask_q & ~runbits;
    lpos    = '0;
    klen    = '0;
    for (int i = 0; i < 8; i++) begin
      if (lowbit[i]) lpos = 3'(i);
      klen = klen + 4'(runbits[i]);
    end
    glo = b_base_q + GRANULE_BITS'(lpos);
    cmd_o.status = ST_OK;
    if (b_mask_q != 8'd0) begin
      rem        = (mask_nx != 8'd0) || b_run_q || (b_tail_q != CMD_NOP);
      cmd_o.kind = CMD_OFFER;
      cmd_o.glo  = glo;
      cmd_o.ghi  = glo + GRANULE_BITS'(klen);
    end else if (b_run_q) begin
      rem        = (b_tail_q != CMD_NOP);
      cmd_o.kind = CMD_OFFER;
      cmd_o.glo  = b_lo_q;
      cmd_o.ghi  = b_hi_q;
    end else begin
      rem        = 1'b0;
      cmd_o.kind = b_tail_q;
      cmd_o.glo  = '0;
      cmd_o.ghi  = '0;
    end
    cmd_o.eob = !rem;
    cmd_o.fin = b_fin_q && !rem;
    if (!rem) cmd_o.status = b_status_q;
    issue      = b_valid_q && cmd_ready_i;
    last_issue = issue && !rem;
  end

  assign cmd_valid_o = b_valid_q;
  assign in_stall_o  = b_valid_q && !last_issue;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q       <= PH_START;
      acc_q      <= '0;
      shift_q    <= '0;
      runs_q     <= '0;
      gpos_q     <= '0;
      held_q     <= '0;
      bidx_q     <= '0;
      err_q      <= ST_OK;
      b_valid_q  <= 1'b0;
      b_mask_q   <= '0;
      b_base_q   <= '0;
      b_run_q    <= 1'b0;
      b_lo_q     <= '0;
      b_hi_q     <= '0;
      b_tail_q   <= CMD_NOP;
      b_fin_q    <= 1'b0;
      b_status_q <= ST_OK;
    end else begin
      // a new byte loads only once the previous one has fully issued
      if (in_acc && ld_any) begin
        b_valid_q  <= 1'b1;
        b_mask_q   <= ld_mask;
        b_base_q   <= {bidx_q[GRANULE_BITS-4:0], 3'b000};
        b_run_q    <= ld_run;
        b_lo_q     <= ld_lo;
        b_hi_q     <= ld_hi;
        b_tail_q   <= ld_tail;
        b_fin_q    <= final_byte_i;
        b_status_q <= ld_status;
      end else if (issue) begin
        if (b_mask_q != 8'd0) b_mask_q <= mask_nx;
        else if (b_run_q) b_run_q <= 1'b0;
        if (!rem) b_valid_q <= 1'b0;
      end
      if (in_acc) begin
        ph_q    <= ph_d;
        acc_q   <= acc_d;
        shift_q <= shift_d;
        runs_q  <= runs_d;
        gpos_q  <= gpos_d;
        held_q  <= held_d;
        bidx_q  <= bidx_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

@@ src/gpd_row_calc.sv @@
// granule to row conversion: multiply stage, then clip to the file
module gpd_row_calc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [gpd_pkg::GRANULE_BITS-1:0] granule_rows_i,
  input  logic [gpd_pkg::ROW_BITS-1:0]     total_rows_i,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  gpd_pkg::gpd_cmd_t cmd_i,
  output logic              ent_valid_o,
  input  logic              ent_ready_i,
  output gpd_pkg::gpd_ent_t ent_o
);
  import gpd_pkg::*;

  localparam int unsigned PW = 2 * GRANULE_BITS;

  logic              m_valid_q, p_valid_q;
  gpd_cmd_t          m_q, p_q;
  logic [PW-1:0]     pf_q, pe_q;
  logic              p_adv;
  logic [PW-1:0]     lim, end_c;

  assign p_adv       = !p_valid_q || ent_ready_i;
  assign cmd_ready_o = !m_valid_q || p_adv;

  always_comb begin
    lim   = PW'(total_rows_i);
    end_c = (pe_q > lim) ? lim : pe_q;
    ent_o.kind      = p_q.kind;
    ent_o.eob       = p_q.eob;
    ent_o.fin       = p_q.fin;
    ent_o.status    = p_q.status;
    ent_o.keep      = pf_q < end_c;
    ent_o.first_row = pf_q[ROW_BITS-1:0];
    ent_o.end_row   = end_c[ROW_BITS-1:0];
  end
  assign ent_valid_o = p_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      m_q       <= '0;
      p_q       <= '0;
      pf_q      <= '0;
      pe_q      <= '0;
    end else begin
      if (cmd_ready_o) begin
        m_valid_q <= cmd_valid_i;
        m_q       <= cmd_i;
      end
      if (p_adv) begin
        p_valid_q <= m_valid_q;
        p_q       <= m_q;
        pf_q      <= PW'(m_q.glo) * PW'(granule_rows_i);
        pe_q      <= PW'(m_q.ghi) * PW'(granule_rows_i);
      end
    end
  end

endmodule

@@ src/gpd_cmd_fifo.sv @@
// command queue between the decoder and the range merger
module gpd_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  gpd_pkg::gpd_ent_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output gpd_pkg::gpd_ent_t rdata_o,
  output logic              empty_o
);
  import gpd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gpd_ent_t        mem_q [DEPTH];
  logic [AW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        mem_q[wp_q] <= wdata_i;
        wp_q        <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      end
      if (pop_i) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CW'(1);
      else if (!push_i && pop_i) cnt_q <= cnt_q - CW'(1);
    end
  end

endmodule

@@ src/gpd_back.sv @@
// range merger with one staged result and an output register
`include "granule_posting_decoder_unit_macros.svh"

module gpd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  gpd_pkg::gpd_ent_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gpd_pkg::gpd_res_t out_o
);
  import gpd_pkg::*;

  logic                open_q, open_d;
  logic [ROW_BITS-1:0] ofirst_q, ofirst_d, oend_q, oend_d;
  logic                s_valid_q, s_valid_d, s_final_q, s_final_d;
  gpd_res_t            s_q, s_d;
  logic                o_valid_q;
  gpd_res_t            o_q;
  logic                r_exists, o_free, s_move, proc;
  gpd_res_t            r_res;

  always_comb begin
    open_d   = open_q;
    ofirst_d = ofirst_q;
    oend_d   = oend_q;
    r_exists = 1'b0;
    case (head_i.kind)
      CMD_OFFER: begin
        if (head_i.keep) begin
          if (open_q && oend_q == head_i.first_row) begin
            oend_d = head_i.end_row;
          end else begin
            r_exists = open_q;
            open_d   = 1'b1;
            ofirst_d = head_i.first_row;
            oend_d   = head_i.end_row;
          end
        end
      end
      CMD_FLUSH: begin
        r_exists = open_q;
        open_d   = 1'b0;
      end
      CMD_DROP: open_d = 1'b0;
      default: ;
    endcase
    if (head_i.fin) open_d = 1'b0;

    r_res              = '0;
    r_res.range_valid  = 1'b1;
    r_res.first_row    = ofirst_q;
    r_res.end_row      = oend_q;

    o_free = !o_valid_q || !out_stall_i;
    s_move = s_valid_q && o_free && (s_final_q || (head_valid_i && r_exists));
    proc   = head_valid_i && (!s_valid_q || (!s_final_q && !r_exists) || s_move);

    s_valid_d = s_valid_q && !s_move;
    s_final_d = s_final_q && !s_move;
    s_d       = s_q;
    if (proc) begin
      if (r_exists) begin
        s_valid_d = 1'b1;
        s_final_d = 1'b0;
        s_d       = r_res;
      end
      if (head_i.eob) begin
        if (s_valid_d) begin
          s_final_d        = 1'b1;
          s_d.last         = 1'b1;
          s_d.posting_done = head_i.fin;
          s_d.status       = head_i.fin ? head_i.status : ST_OK;
        end else if (head_i.fin) begin
          // no range from this byte: empty result carries the status
          s_valid_d        = 1'b1;
          s_final_d        = 1'b1;
          s_d              = '0;
          s_d.last         = 1'b1;
          s_d.posting_done = 1'b1;
          s_d.status       = head_i.status;
        end
      end
    end
  end

  assign pop_o       = proc;
  assign out_valid_o = o_valid_q;
  assign out_o       = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q    <= 1'b0;
      ofirst_q  <= '0;
      oend_q    <= '0;
      s_valid_q <= 1'b0;
      s_final_q <= 1'b0;
      s_q       <= '0;
      o_valid_q <= 1'b0;
      o_q       <= '0;
    end else begin
      if (proc) begin
        open_q   <= open_d;
        ofirst_q <= ofirst_d;
        oend_q   <= oend_d;
      end
      s_valid_q <= s_valid_d;
      s_final_q <= s_final_d;
      s_q       <= s_d;
      if (o_free) begin
        o_valid_q <= s_move;
        if (s_move) o_q <= s_q;
      end
    end
  end

  `GPD_ASSERT_IMP(a_done_is_last, out_valid_o && out_o.posting_done, out_o.last, "done without last")
  `GPD_ASSERT_IMP(a_empty_is_done, out_valid_o && !out_o.range_valid, out_o.posting_done, "empty result not done")
  `GPD_ASSERT_IMP(a_final_kept, proc && s_valid_q && s_final_q, s_move, "staged result overwritten")

endmodule

@@ src/granule_posting_decoder_unit.sv @@
// bytes pass the scan register, row calculator, queue, staged result, output register
// throughput: one byte per cycle at best; the run scanner issues one command per
//   contiguous run of set granules in a bitmap byte and one for the run of a runs
//   byte, plus one more when that byte completes or aborts the posting
// result order kept by a command queue; a full queue or a stalled output holds input
// reset: asynchronous active low; posting state idle, registers 0, 1, 0, 1
module granule_posting_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [39:0] cfg_wdata_i,
  // posting bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  posting_byte_i,
  input  logic        final_byte_i,
  // row ranges
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        range_valid_o,
  output logic [39:0] range_first_row_o,
  output logic [39:0] range_end_row_o,
  output logic        posting_done_o,
  output logic [1:0]  status_o,
  output logic        last_of_input_o
);
  import gpd_pkg::*;

  gpd_cfg_t  cfg_q;
  gpd_cmd_t  cmd;
  logic      cmd_valid, cmd_ready;
  gpd_ent_t  ent, head;
  logic      ent_valid, full, empty, pop;
  gpd_res_t  res;

  // configuration registers; the user must write them only while idle, not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= 1'b0;
      cfg_q.granule_rows  <= GRANULE_BITS'(1);
      cfg_q.total_rows    <= '0;
      cfg_q.granule_count <= GRANULE_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODE:          cfg_q.mode          <= cfg_wdata_i[0];
        CFG_GRANULE_ROWS:  cfg_q.granule_rows  <= cfg_wdata_i[GRANULE_BITS-1:0];
        CFG_TOTAL_ROWS:    cfg_q.total_rows    <= cfg_wdata_i[ROW_BITS-1:0];
        CFG_GRANULE_COUNT: cfg_q.granule_count <= cfg_wdata_i[GRANULE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // front: byte decode and run scan, one command per cycle while cmd_ready is high
  gpd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .posting_byte_i (posting_byte_i),
    .final_byte_i   (final_byte_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  // granule indexes to clipped rows
  gpd_row_calc u_row_calc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .granule_rows_i (cfg_q.granule_rows),
    .total_rows_i   (cfg_q.total_rows),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .ent_valid_o    (ent_valid),
    .ent_ready_i    (!full),
    .ent_o          (ent)
  );

  // decouples decode from merge and output stalls
  gpd_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ent_valid && !full),
    .wdata_i (ent),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (head),
    .empty_o (empty)
  );

  // back: merge ranges, tag last and done, drive the result transfer
  gpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_o        (res)
  );

  assign range_valid_o     = res.range_valid;
  assign range_first_row_o = res.first_row;
  assign range_end_row_o   = res.end_row;
  assign posting_done_o    = res.posting_done;
  assign status_o          = res.status;
  assign last_of_input_o   = res.last;

endmodule
